// ===== rtl/frame_chunk_reassembly_tracker_unit_macros.svh =====
// Assertion helpers shared by the checker.
// Both sample on clk_i and stay quiet while rst_ni is low.
`ifndef FRAME_CHUNK_REASSEMBLY_TRACKER_UNIT_MACROS_SVH
`define FRAME_CHUNK_REASSEMBLY_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication.
`define FCRT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FCRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fcrt_pkg.sv =====
`timescale 1ns / 1ps

package fcrt_pkg;

  localparam int unsigned DefMaxChunks  = 128;
  localparam int unsigned DefFrameBytes = 64000;
  localparam int unsigned DefMaxPayload = 640;

  localparam int unsigned SeqW   = 32;
  localparam int unsigned IdxW   = 16;
  localparam int unsigned TotalW = 16;
  localparam int unsigned LenW   = 10;
  localparam int unsigned OffW   = 16;
  localparam int unsigned ProdW  = IdxW + LenW;

  // One entry of the seen store: the frame that last marked this chunk.
  typedef struct packed {
    logic            vld;
    logic [SeqW-1:0] tag;
  } fcrt_entry_t;

endpackage

// ===== rtl/fcrt_in_if.sv =====
`timescale 1ns / 1ps

interface fcrt_in_if;
  logic                               valid;
  logic                               ready;
  logic [fcrt_pkg::SeqW-1:0]          frame_seq;
  logic [fcrt_pkg::IdxW-1:0]          chunk_index;
  logic [fcrt_pkg::TotalW-1:0]        chunk_total;
  logic [fcrt_pkg::LenW-1:0]          payload_bytes;

  modport source (output valid, frame_seq, chunk_index, chunk_total, payload_bytes,
                  input ready);
  modport sink   (input valid, frame_seq, chunk_index, chunk_total, payload_bytes,
                  output ready);
endinterface

// ===== rtl/fcrt_out_if.sv =====
`timescale 1ns / 1ps

interface fcrt_out_if;
  logic                      valid;
  logic                      ready;
  logic                      write_enable;
  logic [fcrt_pkg::OffW-1:0] write_offset;
  logic                      rejected;
  logic                      frame_dropped;
  logic [fcrt_pkg::SeqW-1:0] dropped_seq;
  logic                      frame_complete;

  modport source (output valid, write_enable, write_offset, rejected, frame_dropped,
                  dropped_seq, frame_complete, input ready);
  modport sink   (input valid, write_enable, write_offset, rejected, frame_dropped,
                  dropped_seq, frame_complete, output ready);
endinterface

// ===== rtl/frame_chunk_reassembly_tracker_unit.sv =====
`timescale 1ns / 1ps

// Frame chunk reassembly tracker.
// in_i carries one chunk header a beat (frame_seq, chunk_index, chunk_total,
// payload_bytes); out_o returns exactly one result beat for each header, in
// order: write enable and framebuffer offset, reject flag, dropped-frame report
// and completion flag.
// Throughput: one header per cycle while the store sweep is done and out_o is not
// stalled. The seen store is read at the accepting edge (the chunk_index *
// payload_bytes product is registered alongside), and the frame state and the
// output register update at the edge on which the read stage fires.
// The seen store holds, per chunk, the sequence of the frame that last marked
// it, so a new frame needs no clearing. A write and a read of the same entry in
// one cycle are forwarded inside the store.
// After reset the store is swept invalid, one entry a cycle: in_i.ready stays
// low until the sweep is done. Frame state and counters reset to zero.
// When out_o stalls the result holds in the output register; one more header
// is taken into the read stage, then in_i.ready drops until out_o drains.
module frame_chunk_reassembly_tracker_unit #(
  parameter int unsigned MAX_CHUNKS  = fcrt_pkg::DefMaxChunks,
  parameter int unsigned FRAME_BYTES = fcrt_pkg::DefFrameBytes,
  parameter int unsigned MAX_PAYLOAD = fcrt_pkg::DefMaxPayload
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  fcrt_in_if.sink           in_i,
  fcrt_out_if.source        out_o
);

  localparam int unsigned AddrW = $clog2(MAX_CHUNKS);
  localparam int unsigned CntW  = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned SumW  = fcrt_pkg::ProdW + 1;
  localparam int unsigned PlW   = 13;

  localparam logic [fcrt_pkg::IdxW:0] ChunkLimit   = (fcrt_pkg::IdxW + 1)'(MAX_CHUNKS);
  localparam logic [PlW-1:0]          PayloadLimit = PlW'(MAX_PAYLOAD);
  localparam logic [SumW-1:0]         FrameLimit   = SumW'(FRAME_BYTES);

  // Read stage
  logic                              s1_valid_q;
  logic [fcrt_pkg::SeqW-1:0]         s1_seq_q;
  logic [fcrt_pkg::IdxW-1:0]         s1_idx_q;
  logic [fcrt_pkg::TotalW-1:0]       s1_total_q;
  logic [fcrt_pkg::LenW-1:0]         s1_len_q;
  logic [fcrt_pkg::ProdW-1:0]        s1_prod_q;

  // Frame state
  logic [fcrt_pkg::SeqW-1:0]         cur_q, cur_d;
  logic [CntW-1:0]                   recv_q, recv_d;
  logic [fcrt_pkg::TotalW-1:0]       exp_q, exp_d;

  // Output register
  logic                              out_valid_q;
  logic                              we_q, we_d;
  logic [fcrt_pkg::OffW-1:0]         off_q, off_d;
  logic                              rej_q, rej_d;
  logic                              drop_q, drop_d;
  logic [fcrt_pkg::SeqW-1:0]         dseq_q, dseq_d;
  logic                              done_q, done_d;

  logic                              in_fire, s1_fire, store_busy;
  fcrt_pkg::fcrt_entry_t             rd_entry;
  logic                              newer, same, rej_idx, rej_off, seen, acc;
  logic [CntW-1:0]                   recv_base;
  logic [SumW-1:0]                   end_byte;

  assign s1_fire     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !store_busy && (!s1_valid_q || s1_fire);
  assign in_fire     = in_i.valid && in_i.ready;

  fcrt_seen_store #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (in_i.chunk_index[AddrW-1:0]),
    .wr_en_i   (s1_fire && acc),
    .wr_addr_i (s1_idx_q[AddrW-1:0]),
    .wr_tag_i  (cur_d),
    .rd_data_o (rd_entry),
    .busy_o    (store_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_seq_q   <= in_i.frame_seq;
      s1_idx_q   <= in_i.chunk_index;
      s1_total_q <= in_i.chunk_total;
      s1_len_q   <= in_i.payload_bytes;
      s1_prod_q  <= fcrt_pkg::ProdW'(in_i.chunk_index) * fcrt_pkg::ProdW'(in_i.payload_bytes);
    end
  end

  // Restart on a newer frame, then handle the chunk against the resulting state.
  always_comb begin
    newer     = s1_seq_q > cur_q;
    cur_d     = newer ? s1_seq_q : cur_q;
    exp_d     = newer ? s1_total_q : exp_q;
    recv_base = newer ? '0 : recv_q;
    same      = (s1_seq_q == cur_d);

    rej_idx   = ({1'b0, s1_idx_q} >= ChunkLimit) || (PlW'(s1_len_q) > PayloadLimit);
    end_byte  = SumW'(s1_prod_q) + SumW'(s1_len_q);
    rej_off   = end_byte > FrameLimit;
    // A restart makes every stored tag stale.
    seen      = !newer && rd_entry.vld && (rd_entry.tag == cur_q);
    acc       = same && !rej_idx && !rej_off && !seen;
    recv_d    = recv_base + CntW'(acc);

    we_d      = acc;
    off_d     = acc ? s1_prod_q[fcrt_pkg::OffW-1:0] : '0;
    rej_d     = same && (rej_idx || rej_off);
    drop_d    = newer && (fcrt_pkg::TotalW'(recv_q) < exp_q);
    dseq_d    = drop_d ? cur_q : '0;
    done_d    = same && (fcrt_pkg::TotalW'(recv_d) == exp_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      recv_q      <= '0;
      exp_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_fire) begin
        cur_q  <= cur_d;
        recv_q <= recv_d;
        exp_q  <= exp_d;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      we_q   <= we_d;
      off_q  <= off_d;
      rej_q  <= rej_d;
      drop_q <= drop_d;
      dseq_q <= dseq_d;
      done_q <= done_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.write_enable   = we_q;
  assign out_o.write_offset   = off_q;
  assign out_o.rejected       = rej_q;
  assign out_o.frame_dropped  = drop_q;
  assign out_o.dropped_seq    = dseq_q;
  assign out_o.frame_complete = done_q;

endmodule

// ===== rtl/fcrt_seen_store.sv =====
`timescale 1ns / 1ps

module fcrt_seen_store #(
  parameter int unsigned MAX_CHUNKS = fcrt_pkg::DefMaxChunks
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  rd_en_i,
  input  logic [$clog2(MAX_CHUNKS)-1:0]         rd_addr_i,
  input  logic                                  wr_en_i,
  input  logic [$clog2(MAX_CHUNKS)-1:0]         wr_addr_i,
  input  logic [fcrt_pkg::SeqW-1:0]             wr_tag_i,
  output fcrt_pkg::fcrt_entry_t                 rd_data_o,
  output logic                                  busy_o
);

  localparam int unsigned AddrW = $clog2(MAX_CHUNKS);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(MAX_CHUNKS - 1);

  fcrt_pkg::fcrt_entry_t mem [MAX_CHUNKS];
  fcrt_pkg::fcrt_entry_t rd_data_q;

  logic             clr_busy_q, clr_busy_d;
  logic [AddrW-1:0] clr_addr_q, clr_addr_d;

  logic                  mem_we;
  logic [AddrW-1:0]      mem_waddr;
  fcrt_pkg::fcrt_entry_t mem_wdata;

  // Sweep every entry to invalid after reset.
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + AddrW'(1);
      if (clr_addr_q == LastAddr) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_comb begin
    if (clr_busy_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else begin
      mem_we        = wr_en_i;
      mem_waddr     = wr_addr_i;
      mem_wdata.vld = 1'b1;
      mem_wdata.tag = wr_tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Forward a write that lands on the entry being read in the same cycle.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (mem_we && (mem_waddr == rd_addr_i)) begin
        rd_data_q <= mem_wdata;
      end else begin
        rd_data_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_busy_q;

endmodule

// ===== rtl/fcrt_checker.sv =====
`timescale 1ns / 1ps

`include "frame_chunk_reassembly_tracker_unit_macros.svh"

module fcrt_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic                      write_enable_i,
  input logic [fcrt_pkg::OffW-1:0] write_offset_i,
  input logic                      rejected_i,
  input logic                      frame_dropped_i,
  input logic [fcrt_pkg::SeqW-1:0] dropped_seq_i
);

  // A stalled result beat stays valid with its offset and dropped sequence held.
  `FCRT_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(write_offset_i) && $stable(dropped_seq_i), "stalled result beat changed")

  `FCRT_ASSERT_NOW(a_we_not_rej, out_valid_i && write_enable_i, !rejected_i, "chunk both written and rejected")

  `FCRT_ASSERT_NOW(a_off_zero, out_valid_i && !write_enable_i, write_offset_i == '0, "offset set without write")

  `FCRT_ASSERT_NOW(a_dseq_zero, out_valid_i && !frame_dropped_i, dropped_seq_i == '0, "dropped sequence set without drop")

endmodule

bind frame_chunk_reassembly_tracker_unit fcrt_checker u_fcrt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .write_enable_i  (out_o.write_enable),
  .write_offset_i  (out_o.write_offset),
  .rejected_i      (out_o.rejected),
  .frame_dropped_i (out_o.frame_dropped),
  .dropped_seq_i   (out_o.dropped_seq)
);
